[rtl/qbs_pkg.sv]
// Package: shared types and constants of the quantized bitonic sorter.
package qbs_pkg;

    localparam int LLR_W  = 10;
    localparam int IDX_W  = 5;
    localparam int STEP_W = 4;
    localparam int CNT_W  = 5;

    typedef struct packed {
        logic [LLR_W-1:0] llr_value;
        logic             last;
    } t_in_beat;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  sorted_index;
        logic [STEP_W-1:0] step_number;
        logic [CNT_W-1:0]  eq_pairs;
        logic [CNT_W-1:0]  valid_count;
        logic              overflow;
        logic              last_out;
    } t_out_beat;

    localparam logic KIND_INDEX = 1'b0;
    localparam logic KIND_STATS = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic pad_clr;
        logic cmp;
        logic stat_rd;
        logic done;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic pad_done;
        logic pair_done;
        logic pass_done;
        logic net_done;
        logic emit_done;
    } t_sts;

endpackage

[rtl/qbs_if.sv]
// Interfaces: valid/ready channels for input and result beats.
interface qbs_in_if;
    logic               valid;
    logic               ready;
    qbs_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qbs_out_if;
    logic               valid;
    logic               ready;
    qbs_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/quantized_bitonic_sorter_tie_stats_unit.sv]
// Top level: quantized bitonic sorter with per-pass tie statistics.
// Usage:
//   in_ch carries one LLR beat (llr_value, last) per accepted handshake.
//   Beats load one per cycle; a beat with last set starts the sort.
//   Beats beyond MAX_ITEMS are dropped and set overflow on the run's results.
//   While sorting and emitting, in_ch.ready stays low.
//   Padding rounds the item count up to a power of two n_eff; each pass visits
//   n_eff slots of the shared compare unit, one a cycle; a sort of 32 items
//   takes 15 passes.
//   out_ch then delivers n index beats, then one statistics beat per pass,
//   last_out set on the final beat; one beat a cycle through the output
//   register when the receiver is ready.
//   A receiver stall holds the output register and the emission counter.
//   Reset (i_rst_n low, synchronous) clears the item count, overflow flag and
//   controller; the key and index memories are left as they are.
module quantized_bitonic_sorter_tie_stats_unit #(
    parameter int MAX_ITEMS = 32,
    parameter int KEY_BITS  = 3,
    parameter int MAG_BITS  = 5
) (
    input logic i_clk,
    input logic i_rst_n,
    qbs_in_if.sink    in_ch,
    qbs_out_if.source out_ch
);
    qbs_pkg::t_cmd      w_cmd;
    qbs_pkg::t_sts      w_sts;
    qbs_pkg::t_out_beat w_res;
    logic               w_emit;
    logic               r_ov;
    qbs_pkg::t_out_beat r_od;
    logic               w_fire;

    assign w_fire = out_ch.valid && out_ch.ready;

    qbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_in_last  (in_ch.data.last),
        .o_in_ready (in_ch.ready),
        .i_out_fire (w_fire),
        .i_out_busy (r_ov),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_emit     (w_emit)
    );

    qbs_dp #(
        .MAX_ITEMS (MAX_ITEMS),
        .KEY_BITS  (KEY_BITS),
        .MAG_BITS  (MAG_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_beat  (in_ch.data),
        .o_sts   (w_sts),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit && w_cmd.stat_rd) begin
            r_ov <= 1'b1;
        end else if (w_fire) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && w_cmd.stat_rd) r_od <= w_res;
    end

    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_od;
endmodule

[rtl/qbs_ctrl.sv]
// Controller: sequences load, pad, compare passes and result emission.
module qbs_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_last,
    output logic         o_in_ready,
    input  logic         i_out_fire,
    input  logic         i_out_busy,
    input  qbs_pkg::t_sts i_sts,
    output qbs_pkg::t_cmd o_cmd,
    output logic         o_emit
);
    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        o_emit  = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) n_state = S_PAD;
            end
            S_PAD: begin
                o_cmd.pad_clr = 1'b1;
                if (i_sts.pad_done) n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.net_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_emit = 1'b1;
                o_cmd.stat_rd = !i_out_busy || i_out_fire;
                if (i_sts.emit_done && o_cmd.stat_rd) begin
                    o_cmd.done = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end
endmodule

[rtl/qbs_dp.sv]
// Datapath: key build, key and index memories, bitonic compare unit, counters.
module qbs_dp #(
    parameter int MAX_ITEMS = 32,
    parameter int KEY_BITS  = 3,
    parameter int MAG_BITS  = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qbs_pkg::t_cmd      i_cmd,
    input  qbs_pkg::t_in_beat  i_beat,
    output qbs_pkg::t_sts      o_sts,
    output qbs_pkg::t_out_beat o_res
);
    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int DEPTH = 1 << AW;
    localparam int NP = AW * (AW + 1) / 2;
    localparam int SW = (MAG_BITS > KEY_BITS) ? MAG_BITS - KEY_BITS : 0;
    localparam logic [KEY_BITS-1:0] KMAX = '1;
    localparam logic [qbs_pkg::LLR_W-1:0] CLIP =
        qbs_pkg::LLR_W'(((1 << MAG_BITS) - 1) * 4);

    logic [KEY_BITS-1:0] r_key [DEPTH];
    logic [qbs_pkg::IDX_W-1:0] r_idx [DEPTH];
    logic [AW:0]   r_cnt;
    logic          r_ovf;
    logic [qbs_pkg::CNT_W-1:0] r_tie [NP];
    logic [qbs_pkg::CNT_W-1:0] r_vld [NP];

    logic [AW:0]   r_neff;
    logic [AW:0]   r_pos;
    logic [AW:0]   r_w;
    logic [AW-1:0] r_j;
    logic [qbs_pkg::STEP_W-1:0] r_pass;
    logic [AW:0]   r_ep;

    // key build
    logic [qbs_pkg::LLR_W-1:0] v_mag;
    logic [qbs_pkg::LLR_W-1:0] v_q;
    logic [KEY_BITS-1:0]       v_key;
    always_comb begin
        v_mag = i_beat.llr_value[qbs_pkg::LLR_W-1] ? (~i_beat.llr_value + 1'b1)
                                                   : i_beat.llr_value;
        if (v_mag > CLIP) v_mag = CLIP;
        v_q   = (v_mag + qbs_pkg::LLR_W'(2)) >> 2;
        v_key = KEY_BITS'(v_q >> SW);
    end

    logic v_full;
    assign v_full = (r_cnt >= (AW+1)'(MAX_ITEMS));

    // compare unit over pair i, l = i ^ j
    logic [AW-1:0] v_i, v_l;
    logic          v_lo, v_up, v_swap, v_real, v_tie;
    logic [KEY_BITS-1:0] v_ki, v_kl;
    always_comb begin
        v_i  = r_pos[AW-1:0];
        v_l  = v_i ^ r_j;
        v_lo = (v_l > v_i) && (r_pos < r_neff);
        v_ki = r_key[v_i];
        v_kl = r_key[v_l];
        v_up = ((AW+1)'(v_i) & r_w) == '0;
        v_swap = v_up ? (v_ki > v_kl) : (v_ki < v_kl);
        v_real = ((AW+1)'(v_i) < r_cnt) && ((AW+1)'(v_l) < r_cnt);
        v_tie  = v_ki == v_kl;
    end

    logic v_pass_end, v_net_end, v_pad_end;
    assign v_pass_end = (r_pos == r_neff - 1'b1);
    assign v_net_end  = v_pass_end && (r_j == AW'(1)) && (r_w == r_neff);
    assign v_pad_end  = (r_neff != '0) && (r_neff >= r_cnt) && (r_pos >= r_neff - 1'b1);

    assign o_sts.full      = v_full;
    assign o_sts.pad_done  = v_pad_end;
    assign o_sts.pair_done = 1'b1;
    assign o_sts.pass_done = v_pass_end;
    assign o_sts.net_done  = (r_neff < (AW+1)'(2)) || v_net_end;
    assign o_sts.emit_done = (r_ep == r_cnt + (AW+1)'(r_pass) - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_pos <= '0;
            r_ep  <= '0;
            r_pass <= '0;
        end else begin
            if (i_cmd.load) begin
                if (v_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_key[r_cnt[AW-1:0]] <= v_key;
                    r_idx[r_cnt[AW-1:0]] <= qbs_pkg::IDX_W'(r_cnt);
                    r_cnt <= r_cnt + 1'b1;
                end
                if (i_beat.last) begin
                    r_pos  <= (AW+1)'(v_full ? r_cnt : r_cnt + 1'b1);
                    r_neff <= '0;
                    r_pass <= '0;
                    for (int p = 0; p < NP; p++) begin
                        r_tie[p] <= '0;
                        r_vld[p] <= '0;
                    end
                end
            end
            if (i_cmd.pad_clr) begin
                if (v_pad_end) begin
                    if (r_pos < r_neff) begin
                        r_key[r_pos[AW-1:0]] <= KMAX;
                        r_idx[r_pos[AW-1:0]] <= qbs_pkg::IDX_W'(r_pos);
                    end
                    r_pos <= '0;
                    r_w   <= (AW+1)'(2);
                    r_j   <= AW'(1);
                end else if (r_neff == '0) begin
                    r_neff <= (AW+1)'(1);
                    r_pos  <= r_cnt;
                end else if (r_neff < r_cnt) begin
                    r_neff <= r_neff << 1;
                end else if (r_pos < r_neff) begin
                    r_key[r_pos[AW-1:0]] <= KMAX;
                    r_idx[r_pos[AW-1:0]] <= qbs_pkg::IDX_W'(r_pos);
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (i_cmd.cmp && r_neff >= (AW+1)'(2)) begin
                if (v_lo) begin
                    if (v_real) begin
                        r_vld[r_pass] <= r_vld[r_pass] + 1'b1;
                        if (v_tie) r_tie[r_pass] <= r_tie[r_pass] + 1'b1;
                    end
                    if (v_swap) begin
                        r_key[v_i] <= v_kl;
                        r_key[v_l] <= v_ki;
                        r_idx[v_i] <= r_idx[v_l];
                        r_idx[v_l] <= r_idx[v_i];
                    end
                end
                if (v_pass_end) begin
                    r_pos  <= '0;
                    r_pass <= r_pass + 1'b1;
                    if (r_j == AW'(1)) begin
                        r_w <= r_w << 1;
                        r_j <= AW'(r_w);
                    end else begin
                        r_j <= r_j >> 1;
                    end
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (i_cmd.cmp && o_sts.net_done) r_ep <= '0;
            if (i_cmd.stat_rd) r_ep <= r_ep + 1'b1;
            if (i_cmd.done) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end
        end
    end

    // result beat for emission position r_ep
    logic [AW:0] v_sp;
    always_comb begin
        v_sp = r_ep - r_cnt;
        o_res = '0;
        o_res.overflow = r_ovf;
        o_res.last_out = o_sts.emit_done;
        if (r_ep < r_cnt) begin
            o_res.kind = qbs_pkg::KIND_INDEX;
            o_res.sorted_index = r_idx[r_ep[AW-1:0]];
        end else begin
            o_res.kind = qbs_pkg::KIND_STATS;
            o_res.step_number = qbs_pkg::STEP_W'(v_sp);
            o_res.eq_pairs    = r_tie[qbs_pkg::STEP_W'(v_sp)];
            o_res.valid_count = r_vld[qbs_pkg::STEP_W'(v_sp)];
        end
    end
endmodule
